@@ hw/rtl/tlpt_pkg.sv @@
// Shared constants, types and codes of the two-level page table engine.
package tlpt_pkg;

	// Number of page tables in the fixed pool.
	localparam int TABLE_POOL  = 32;

	localparam int SLOT_COUNT  = 1024;
	localparam int ENTRY_COUNT = 1024;
	localparam int OFFSET_W    = 12;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
	localparam int SLOT_LSB    = OFFSET_W + ENTRY_W;

	localparam int TBL_W       = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
	localparam int CNT_W       = $clog2(TABLE_POOL + 1);
	localparam int DIR_W       = TBL_W + 1;
	localparam int PAGE_DEPTH  = TABLE_POOL * ENTRY_COUNT;
	localparam int PAGE_AW     = $clog2(PAGE_DEPTH);

	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef logic [TBL_W-1:0]   tbl_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [PAGE_AW-1:0] page_addr_t;

	typedef struct packed {
		logic valid;
		tbl_t tbl;
	} dir_entry_t;

	typedef enum logic [1:0] {
		CMD_MAP   = 2'd0,
		CMD_UNMAP = 2'd1,
		CMD_XLATE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		RES_OK,
		RES_FAIL,
		RES_MISS,
		RES_HIT
	} res_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIR,
		ST_PAGE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      clr_step;
		logic      cap;
		logic      alloc;
		logic      page_wr;
		logic      page_rd;
		logic      out_load;
		res_kind_t res;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic slot_valid;
		logic pool_full;
		logic page_present;
		logic clr_last;
	} sts_t;

endpackage

@@ hw/rtl/tlpt_req_if.sv @@
// Request channel: one command word with valid/ready handshake.
interface tlpt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] virt_addr;
	logic [31:0] phys_addr;
	logic [11:0] page_flags;

	modport source (output valid, output cmd, output virt_addr, output phys_addr,
		output page_flags, input ready);
	modport sink (input valid, input cmd, input virt_addr, input phys_addr,
		input page_flags, output ready);
endinterface

@@ hw/rtl/tlpt_rsp_if.sv @@
// Response channel: one result word with valid/ready handshake.
interface tlpt_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [31:0] phys_result;

	modport source (output valid, output ok, output phys_result, input ready);
	modport sink (input valid, input ok, input phys_result, output ready);
endinterface

@@ hw/rtl/tlpt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tlpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/tlpt_datapath.sv @@
// Datapath: directory and page memories, pool counter, clearing sweep and result register.
module tlpt_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  tlpt_pkg::ctl_t    ctl,
	output tlpt_pkg::sts_t    sts,
	input  logic [1:0]        cmd,
	input  logic [31:0]       virt_addr,
	input  logic [31:0]       phys_addr,
	input  logic [11:0]       page_flags,
	output logic              ok,
	output logic [31:0]       phys_result
);

	logic [1:0]             cmd_q;
	logic [31:0]            va_q;
	logic [31:0]            pa_q;
	logic [11:0]            flags_q;
	tlpt_pkg::cnt_t         used_q;
	tlpt_pkg::page_addr_t   clr_q;
	logic                   ok_q;
	logic [31:0]            phys_q;

	tlpt_pkg::dir_entry_t   dir_rdata;
	logic [31:0]            page_rdata;

	logic                   dir_wr_en;
	tlpt_pkg::slot_t        dir_wr_addr;
	tlpt_pkg::dir_entry_t   dir_wr_data;
	tlpt_pkg::tbl_t         op_tbl;
	tlpt_pkg::page_addr_t   op_addr;
	logic                   page_wr_en;
	tlpt_pkg::page_addr_t   page_wr_addr;
	logic [31:0]            page_wr_data;
	logic                   sweep_dir;

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q   <= cmd;
			va_q    <= virt_addr;
			pa_q    <= phys_addr;
			flags_q <= page_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			clr_q  <= '0;
		end else begin
			if (ctl.clr_step) begin
				clr_q <= clr_q + tlpt_pkg::page_addr_t'(1);
			end
			if (ctl.alloc) begin
				used_q <= used_q + tlpt_pkg::cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			unique case (ctl.res)
				tlpt_pkg::RES_OK: begin
					ok_q   <= 1'b1;
					phys_q <= '0;
				end
				tlpt_pkg::RES_FAIL: begin
					ok_q   <= 1'b0;
					phys_q <= '0;
				end
				tlpt_pkg::RES_MISS: begin
					ok_q   <= 1'b1;
					phys_q <= tlpt_pkg::MISS_VALUE;
				end
				tlpt_pkg::RES_HIT: begin
					ok_q   <= 1'b1;
					phys_q <= {page_rdata[31:tlpt_pkg::OFFSET_W],
						va_q[tlpt_pkg::OFFSET_W-1:0]};
				end
				default: begin
					ok_q   <= 1'b1;
					phys_q <= '0;
				end
			endcase
		end
	end

	// The sweep clears the directory during its first SLOT_COUNT steps.
	assign sweep_dir = ((clr_q >> tlpt_pkg::SLOT_W) == '0);

	always_comb begin
		op_tbl  = ctl.alloc ? used_q[tlpt_pkg::TBL_W-1:0] : dir_rdata.tbl;
		op_addr = tlpt_pkg::page_addr_t'({op_tbl,
			va_q[tlpt_pkg::OFFSET_W +: tlpt_pkg::ENTRY_W]});

		if (ctl.clr_step) begin
			dir_wr_en    = sweep_dir;
			dir_wr_addr  = clr_q[tlpt_pkg::SLOT_W-1:0];
			dir_wr_data  = '0;
			page_wr_en   = 1'b1;
			page_wr_addr = clr_q;
			page_wr_data = '0;
		end else begin
			dir_wr_en         = ctl.alloc;
			dir_wr_addr       = va_q[tlpt_pkg::SLOT_LSB +: tlpt_pkg::SLOT_W];
			dir_wr_data.valid = 1'b1;
			dir_wr_data.tbl   = used_q[tlpt_pkg::TBL_W-1:0];
			page_wr_en        = ctl.page_wr;
			page_wr_addr      = op_addr;
			page_wr_data      = (cmd_q == tlpt_pkg::CMD_MAP) ?
				{pa_q[31:tlpt_pkg::OFFSET_W], flags_q} : '0;
		end
	end

	tlpt_ram #(
		.WIDTH (tlpt_pkg::DIR_W),
		.DEPTH (tlpt_pkg::SLOT_COUNT)
	) u_dir_ram (
		.clk     (clk),
		.wr_en   (dir_wr_en),
		.wr_addr (dir_wr_addr),
		.wr_data (dir_wr_data),
		.rd_en   (ctl.cap),
		.rd_addr (virt_addr[tlpt_pkg::SLOT_LSB +: tlpt_pkg::SLOT_W]),
		.rd_data (dir_rdata)
	);

	tlpt_ram #(
		.WIDTH (32),
		.DEPTH (tlpt_pkg::PAGE_DEPTH)
	) u_page_ram (
		.clk     (clk),
		.wr_en   (page_wr_en),
		.wr_addr (page_wr_addr),
		.wr_data (page_wr_data),
		.rd_en   (ctl.page_rd),
		.rd_addr (op_addr),
		.rd_data (page_rdata)
	);

	assign sts.cmd          = tlpt_pkg::cmd_t'(cmd_q);
	assign sts.slot_valid   = dir_rdata.valid;
	assign sts.pool_full    = (used_q == tlpt_pkg::cnt_t'(tlpt_pkg::TABLE_POOL));
	assign sts.page_present = page_rdata[0];
	assign sts.clr_last     = (clr_q == tlpt_pkg::page_addr_t'(tlpt_pkg::PAGE_DEPTH - 1));

	assign ok          = ok_q;
	assign phys_result = phys_q;

	// The bump counter never runs past the pool.
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= tlpt_pkg::cnt_t'(tlpt_pkg::TABLE_POOL))
		else $error("table pool counter overran the pool");

	// A table is only taken for an empty slot while the pool has one left.
	a_alloc_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc |-> (!sts.pool_full && !dir_rdata.valid && ctl.page_wr))
		else $error("table allocated without need or without room");

	// A failed result only comes from a map that found the pool exhausted.
	a_fail_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_load && ctl.res == tlpt_pkg::RES_FAIL) |->
		(sts.pool_full && !dir_rdata.valid && cmd_q == tlpt_pkg::CMD_MAP))
		else $error("map failure reported with tables still free");

	// The clearing sweep owns both memories while it runs.
	a_sweep_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_step |-> !(ctl.cap || ctl.alloc || ctl.page_wr || ctl.out_load))
		else $error("command issued during the clearing sweep");

endmodule

@@ hw/rtl/tlpt_ctrl.sv @@
// Controller: state machine sequencing the sweep, directory and page lookups.
module tlpt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  tlpt_pkg::sts_t  sts,
	output tlpt_pkg::ctl_t  ctl
);

	tlpt_pkg::state_t state_q;
	tlpt_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlpt_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlpt_pkg::ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = tlpt_pkg::ST_IDLE;
				end
			end
			tlpt_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = tlpt_pkg::ST_DIR;
				end
			end
			tlpt_pkg::ST_DIR: begin
				if (out_free) begin
					if (sts.cmd == tlpt_pkg::CMD_XLATE && sts.slot_valid) begin
						state_d = tlpt_pkg::ST_PAGE;
					end else begin
						state_d = tlpt_pkg::ST_IDLE;
					end
				end
			end
			tlpt_pkg::ST_PAGE: begin
				if (out_free) begin
					state_d = tlpt_pkg::ST_IDLE;
				end
			end
			default: state_d = tlpt_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl       = '0;
		ctl.res   = tlpt_pkg::RES_OK;
		req_ready = 1'b0;
		unique case (state_q)
			tlpt_pkg::ST_CLEAR: begin
				ctl.clr_step = 1'b1;
			end
			tlpt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				ctl.cap   = req_valid;
			end
			tlpt_pkg::ST_DIR: begin
				if (out_free) begin
					unique case (sts.cmd)
						tlpt_pkg::CMD_MAP: begin
							ctl.out_load = 1'b1;
							if (sts.slot_valid) begin
								ctl.page_wr = 1'b1;
							end else if (sts.pool_full) begin
								ctl.res = tlpt_pkg::RES_FAIL;
							end else begin
								ctl.alloc   = 1'b1;
								ctl.page_wr = 1'b1;
							end
						end
						tlpt_pkg::CMD_UNMAP: begin
							ctl.out_load = 1'b1;
							ctl.page_wr  = sts.slot_valid;
						end
						tlpt_pkg::CMD_XLATE: begin
							if (sts.slot_valid) begin
								ctl.page_rd = 1'b1;
							end else begin
								ctl.out_load = 1'b1;
								ctl.res      = tlpt_pkg::RES_MISS;
							end
						end
						default: begin
							ctl.out_load = 1'b1;
						end
					endcase
				end
			end
			tlpt_pkg::ST_PAGE: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					ctl.res      = sts.page_present ? tlpt_pkg::RES_HIT : tlpt_pkg::RES_MISS;
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	// One command at a time: an accepted word is never followed at once by another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second command accepted while one is in flight");

endmodule

@@ hw/rtl/two_level_page_table_engine_unit.sv @@
// Top level of the two-level page table engine: controller plus datapath.
//
// The engine keeps a 32-bit, two-level page table: 1024 directory slots, each
// pointing at one of a fixed pool of page tables of 1024 entries, 4 KiB pages.
// Commands arrive as words on the req channel (map, unmap or translate) and
// each yields exactly one result word on the rsp channel (ok flag and the
// translated address, all ones on a miss, zero for map and unmap).
// A word is accepted when valid and ready are both high at a clock edge.
//
// For map, unmap and a translate that misses in the directory, the result
// word is loaded into the output register once the directory has been read,
// and the receiver can take it from there. A translate that reaches a page
// table also reads the page-entry memory before its result is registered.
// The order is set by two dependent reads of synchronous memories, first the
// directory, then the page-entry memory. The engine works on one command at a
// time and takes the next one in the cycle after the previous result is
// registered, even while that result still waits.
//
// After reset (arst_n low, asynchronous) a clearing sweep zeroes the directory
// and the page-entry memory, one entry per cycle, over TABLE_POOL * 1024 entries
// (32768 with the pool of 32); req.ready stays low meanwhile.
// If the receiver stalls, the result is held in the output register and the
// engine waits with the next command's directory result until it is taken.
module two_level_page_table_engine_unit (
	input logic        clk,
	input logic        arst_n,
	tlpt_req_if.sink   req,
	tlpt_rsp_if.source rsp
);

	// Control and status between the state machine and the datapath.
	tlpt_pkg::ctl_t ctl;
	tlpt_pkg::sts_t sts;

	// The controller owns the handshakes and the output valid flag.
	tlpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// The datapath holds both memories, the pool counter and the result word.
	tlpt_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (req.cmd),
		.virt_addr   (req.virt_addr),
		.phys_addr   (req.phys_addr),
		.page_flags  (req.page_flags),
		.ok          (rsp.ok),
		.phys_result (rsp.phys_result)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the two-level page table engine unit.
module tb;
	import tlpt_pkg::*;

	// Command code 3 is not used by the engine: it must answer ok with a zero address.
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// Random words after the directed table, spread evenly over four idling phases.
	localparam int RANDOM_WORDS = 1250;
	localparam int PHASES       = 4;

	// The random traffic draws its directory slots from a small set, larger than the
	// table pool, so that translates hit live entries and the pool runs dry early on.
	localparam int HOT_SLOTS    = 48;

	// Length of the deliberate hold-off on the response side, in cycles.
	localparam int HOLD_CYCLES  = 300;

	// Most mismatch lines printed; later ones are still counted.
	localparam int MAX_REPORTS  = 60;

	typedef struct packed {
		logic        ok;
		logic [31:0] phys;
	} result_t;

	// One row of the directed table. Where known is set, the expected word is typed in
	// the row; otherwise it comes from the predictor.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] va;
		logic [31:0] pa;
		logic [11:0] fl;
		logic        known;
		result_t     res;
	} row_t;

	localparam int NUM_ROWS = 22;

	// The opening rows walk an empty table, then the extremes of the address fields,
	// a map whose present bit is clear, unmap and translate of empty slots, the unused
	// command code, a remap of a live entry and a physical address whose offset bits
	// must be dropped. Exhaustion of the table pool is reached by the random part.
	localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, MISS_VALUE}},
		'{CMD_UNMAP, 32'h1234_5678, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, 32'h0}},
		'{CMD_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF, 1'b1, '{1'b1, 32'h0}},
		'{CMD_XLATE, 32'h0000_0ABC, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, 32'hFFFF_FABC}},
		'{CMD_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 12'h001, 1'b1, '{1'b1, 32'h0}},
		'{CMD_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, 32'h0000_0FFF}},
		'{CMD_MAP,   32'hFFFF_E000, 32'h1234_5678, 12'h000, 1'b1, '{1'b1, 32'h0}},
		'{CMD_XLATE, 32'hFFFF_E123, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, MISS_VALUE}},
		'{CMD_UNMAP, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, 32'h0}},
		'{CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, MISS_VALUE}},
		'{CMD_XLATE, 32'h0000_1000, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, MISS_VALUE}},
		'{CMD_SPARE, 32'h89AB_CDEF, 32'hFFFF_FFFF, 12'hFFF, 1'b1, '{1'b1, 32'h0}},
		'{CMD_MAP,   32'h0040_0000, 32'h8000_0000, 12'h801, 1'b0, '{1'b0, 32'h0}},
		'{CMD_XLATE, 32'h0040_0FFF, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, 32'h8000_0FFF}},
		'{CMD_MAP,   32'h0040_0000, 32'h7FFF_F000, 12'h555, 1'b0, '{1'b0, 32'h0}},
		'{CMD_XLATE, 32'h0040_0000, 32'h0000_0000, 12'h000, 1'b0, '{1'b0, 32'h0}},
		'{CMD_MAP,   32'h8000_0000, 32'hABCD_EFFF, 12'h001, 1'b0, '{1'b0, 32'h0}},
		'{CMD_XLATE, 32'h8000_0321, 32'h0000_0000, 12'h000, 1'b0, '{1'b0, 32'h0}},
		'{CMD_UNMAP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000, 1'b0, '{1'b0, 32'h0}},
		'{CMD_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, MISS_VALUE}},
		'{CMD_SPARE, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, '{1'b1, 32'h0}},
		'{CMD_UNMAP, 32'h7FC0_0000, 32'h0000_0000, 12'h000, 1'b0, '{1'b0, 32'h0}}
	};

	logic clk;
	logic arst_n;

	tlpt_req_if req();
	tlpt_rsp_if rsp();

	two_level_page_table_engine_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Predicted page table: directory slots, the pool counter and the page entries.
	logic        dir_live [SLOT_COUNT];
	tbl_t        dir_tbl  [SLOT_COUNT];
	int          tables_taken;
	logic [31:0] pte_mem  [PAGE_DEPTH];

	// Result words still owed by the engine, oldest first.
	result_t     pending_results [$];

	int          error_count;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_asked;
	int          hold_seen;
	int          hold_left;
	slot_t       hot_slots [HOT_SLOTS];

	// Free-running clock, 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one command to the predicted page table and returns the word it yields.
	function automatic result_t walk_command(input logic [1:0] cmd, input logic [31:0] va,
			input logic [31:0] pa, input logic [11:0] fl);
		slot_t       slot;
		int          idx;
		logic [31:0] pte;
		result_t     r;
		slot = va[31:22];
		r.ok = 1'b1;
		r.phys = '0;
		case (cmd)
			CMD_MAP: begin
				// An empty slot takes the next table from the pool, freshly zeroed.
				if (!dir_live[slot]) begin
					if (tables_taken >= TABLE_POOL) begin
						r.ok = 1'b0;
					end else begin
						for (int i = 0; i < ENTRY_COUNT; i++)
							pte_mem[tables_taken * ENTRY_COUNT + i] = '0;
						dir_tbl[slot] = tbl_t'(tables_taken);
						dir_live[slot] = 1'b1;
						tables_taken++;
					end
				end
				if (r.ok) begin
					idx = int'(dir_tbl[slot]) * ENTRY_COUNT + int'(va[21:12]);
					pte_mem[idx] = {pa[31:12], fl};
				end
			end
			CMD_UNMAP: begin
				if (dir_live[slot]) begin
					idx = int'(dir_tbl[slot]) * ENTRY_COUNT + int'(va[21:12]);
					pte_mem[idx] = '0;
				end
			end
			CMD_XLATE: begin
				r.phys = MISS_VALUE;
				if (dir_live[slot]) begin
					idx = int'(dir_tbl[slot]) * ENTRY_COUNT + int'(va[21:12]);
					pte = pte_mem[idx];
					if (pte[0])
						r.phys = {pte[31:12], va[11:0]};
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Compares the result word just taken with the oldest one expected.
	task automatic check_word();
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected word ok=%0b phys=%h", rsp.ok,
				rsp.phys_result));
			return;
		end
		want = pending_results.pop_front();
		if (rsp.ok !== want.ok)
			report_mismatch($sformatf("ok is %0b, expected %0b", rsp.ok, want.ok));
		if (rsp.phys_result !== want.phys)
			report_mismatch($sformatf("phys_result is %h, expected %h", rsp.phys_result,
				want.phys));
	endtask

	// Offers one command word, after random idle cycles, and holds it until the engine
	// takes it. The expected word is queued at the edge of acceptance; the engine
	// reads its directory first, so it can never overtake its own expectation.
	// Valid is left high afterwards, so that back-to-back words never drop it.
	task automatic send_word(input logic [1:0] cmd, input logic [31:0] va,
			input logic [31:0] pa, input logic [11:0] fl, input logic known,
			input result_t given);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.cmd        <= cmd;
		req.virt_addr  <= va;
		req.phys_addr  <= pa;
		req.page_flags <= fl;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		predicted = walk_command(cmd, va, pa, fl);
		pending_results.push_back(known ? given : predicted);
	endtask

	// Most random words are well-formed commands on a small set of slots and entries, so
	// that maps, unmaps and translates meet each other; the rest is noise over every
	// bit of every field, the unused command code included.
	task automatic send_random();
		logic [1:0]  cmd;
		logic [31:0] va;
		logic [31:0] pa;
		logic [11:0] fl;
		int          roll;
		pa = $urandom;
		fl = 12'($urandom);
		roll = $urandom_range(99);
		if (roll < 12) begin
			cmd = 2'($urandom);
			va = $urandom;
		end else begin
			roll = $urandom_range(99);
			cmd = (roll < 35) ? CMD_MAP : (roll < 50) ? CMD_UNMAP : CMD_XLATE;
			va = {hot_slots[$urandom_range(HOT_SLOTS - 1)], 10'($urandom_range(7)),
				12'($urandom)};
			// Mostly present entries, but now and then one whose present bit is clear.
			if ($urandom_range(9) != 0)
				fl[0] = 1'b1;
		end
		send_word(cmd, va, pa, fl, 1'b0, '0);
	endtask

	// Response side: checks each word taken, then picks ready for the next cycle. A
	// hold-off asked for by the stimulus keeps ready low for a long stretch, counted here,
	// so that the engine fills its output register and then stalls the request side.
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				check_word();
			if (hold_asked != hold_seen) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Stimulus: reset, the directed table, then the random part in four idling phases.
	initial begin
		int wait_cycles;
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.cmd        <= CMD_MAP;
		req.virt_addr  <= '0;
		req.phys_addr  <= '0;
		req.page_flags <= '0;
		error_count   = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_asked    = 0;
		hold_seen     = 0;
		hold_left     = 0;
		tables_taken  = 0;
		foreach (dir_live[i]) begin
			dir_live[i] = 1'b0;
			dir_tbl[i] = '0;
		end
		foreach (pte_mem[i])
			pte_mem[i] = '0;
		foreach (hot_slots[i])
			hot_slots[i] = slot_t'($urandom);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The engine sweeps its memories clear after reset; the first word simply waits
		// for ready.
		foreach (DIRECTED_ROWS[i])
			send_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].va, DIRECTED_ROWS[i].pa,
				DIRECTED_ROWS[i].fl, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].res);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 77;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 77;
				end
				default: begin
					send_idle_pct = 28;
					stall_pct = 28;
				end
			endcase
			for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
				// Early in the busiest phase the response side holds off for a long
				// stretch while words keep being offered.
				if (ph == 0 && n == 60)
					hold_asked++;
				send_random();
			end
		end
		req.valid <= 1'b0;

		// Drain: every accepted word owes exactly one result word.
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		// A further wait in which no stray word may turn up.
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				pending_results.size()));

		if (error_count == 0) begin
			$display("two_level_page_table_engine_unit verification clean");
		end else begin
			$display("two_level_page_table_engine_unit verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the clearing sweep plus the slowest run of the stimulus.
	initial begin
		#5000000;
		$display("two_level_page_table_engine_unit verification failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/tlpt_pkg.sv
hw/rtl/tlpt_req_if.sv
hw/rtl/tlpt_rsp_if.sv
hw/rtl/tlpt_ram.sv
hw/rtl/tlpt_datapath.sv
hw/rtl/tlpt_ctrl.sv
hw/rtl/two_level_page_table_engine_unit.sv
tb/tb.sv
